FILE: design/cks_pkg.sv
// shared constants and types of the composite key record sorter
// no dependencies
package cks_pkg;
	localparam int StoreDepth = 64;
	localparam int IdxW = $clog2(StoreDepth);
	localparam int CntW = $clog2(StoreDepth + 1);
	localparam int KeyW = 144;
	localparam int RecW = 160;

	typedef struct packed {
		logic [15:0] key_top;
		logic [31:0] key_hi_hi;
		logic [31:0] key_hi_lo;
		logic [31:0] key_lo_hi;
		logic [31:0] key_lo_lo;
		logic [15:0] tag;
	} rec_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_DRAIN_RD,
		ST_DRAIN_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic sort_start;
		logic sort_rd;
		logic sort_cmp;
		logic drain_start;
		logic drain_rd;
		logic drain_next;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic sort_done;
		logic cmp_shift;
		logic drain_last;
	} stat_t;
endpackage

FILE: design/cks_if.sv
// valid/ready channel carrying one record transaction
// depends on cks_pkg
interface cks_if;
	import cks_pkg::*;
	logic valid;
	logic ready;
	rec_t rec;
	logic last;
	logic ovf;
	modport source (output valid, output rec, output last, output ovf, input ready);
	modport sink (input valid, input rec, input last, input ovf, output ready);
endinterface

FILE: design/cks_datapath.sv
// record store memory, insertion sort pointers and key compare
// depends on cks_pkg
module cks_datapath (
	input  logic clk,
	input  logic arst_n,
	input  cks_pkg::cmd_t cmd,
	input  cks_pkg::rec_t in_rec,
	output cks_pkg::stat_t stat,
	output cks_pkg::rec_t rd_rec
);
	import cks_pkg::*;

	rec_t mem [StoreDepth];
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] i_q;
	logic [CntW-1:0] j_q;
	rec_t cur_q;
	rec_t rd_q;
	logic after;
	logic wr_en;
	logic [IdxW-1:0] wr_addr;
	logic [IdxW-1:0] rd_addr;
	rec_t wr_data;

	assign after = {rd_q.key_top, rd_q.key_hi_hi, rd_q.key_hi_lo, rd_q.key_lo_hi,
		rd_q.key_lo_lo} > {cur_q.key_top, cur_q.key_hi_hi, cur_q.key_hi_lo,
		cur_q.key_lo_hi, cur_q.key_lo_lo};

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cnt_q[IdxW-1:0];
		wr_data = in_rec;
		rd_addr = j_q[IdxW-1:0];
		if (cmd.load && cnt_q != CntW'(StoreDepth)) begin
			wr_en = 1'b1;
		end else if (cmd.sort_cmp) begin
			wr_en = 1'b1;
			wr_addr = j_q[IdxW-1:0];
			wr_data = (j_q != '0 && after) ? rd_q : cur_q;
		end
		if (cmd.sort_rd) rd_addr = IdxW'(j_q - 1'b1);
		if (cmd.drain_rd) rd_addr = i_q[IdxW-1:0];
	end

	// read register only moves on a read command so the drained record holds
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.sort_rd || cmd.drain_rd) rd_q <= mem[rd_addr];
	end

	// cur_q holds the record being inserted, read at sort start and again as each insertion ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.clear) cnt_q <= '0;
			else if (wr_en && cmd.load) cnt_q <= cnt_q + 1'b1;
			if (cmd.sort_start) begin
				i_q <= CntW'(1);
				j_q <= CntW'(1);
			end else if (cmd.sort_cmp) begin
				if (j_q != '0 && after) j_q <= j_q - 1'b1;
				else begin
					i_q <= i_q + 1'b1;
					j_q <= i_q + 1'b1;
				end
			end else if (cmd.drain_start) begin
				i_q <= '0;
			end else if (cmd.drain_next) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	// the last record may land in entry 1 in the same cycle, take it from the input
	always_ff @(posedge clk) begin
		if (cmd.sort_start)
			cur_q <= (wr_en && wr_addr == IdxW'(1)) ? in_rec : mem[IdxW'(1)];
		else if (cmd.sort_cmp && !(j_q != '0 && after))
			cur_q <= mem[IdxW'(i_q + 1'b1)];
	end

	assign stat.full = cnt_q == CntW'(StoreDepth);
	assign stat.sort_done = i_q >= cnt_q;
	assign stat.cmp_shift = j_q != '0 && after;
	assign stat.drain_last = i_q + 1'b1 == cnt_q;
	assign rd_rec = rd_q;
endmodule

FILE: design/cks_ctrl.sv
// controller state machine: load, insertion sort, drain
// depends on cks_pkg
module cks_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	input  logic out_ready,
	input  cks_pkg::stat_t stat,
	output logic in_ready,
	output logic out_valid,
	output logic out_last,
	output logic out_ovf,
	output cks_pkg::cmd_t cmd
);
	import cks_pkg::*;

	state_t state_q, state_d;
	logic ovf_q;
	logic in_acc;

	assign in_acc = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (in_acc && in_last) state_d = ST_SORT_RD;
			ST_SORT_RD: state_d = stat.sort_done ? ST_DRAIN_RD : ST_SORT_CMP;
			ST_SORT_CMP: state_d = ST_SORT_RD;
			ST_DRAIN_RD: state_d = ST_DRAIN_OUT;
			ST_DRAIN_OUT: if (out_ready) state_d = stat.drain_last ? ST_LOAD : ST_DRAIN_RD;
			default: state_d = ST_LOAD;
		endcase
	end

	// sort_start issued with the last load: pointers reset as the record lands
	always_comb begin
		cmd = '0;
		in_ready = state_q == ST_LOAD;
		out_valid = state_q == ST_DRAIN_OUT;
		out_last = stat.drain_last;
		out_ovf = ovf_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load = in_acc;
				cmd.sort_start = in_acc && in_last;
			end
			ST_SORT_RD: begin
				cmd.sort_rd = !stat.sort_done;
				cmd.drain_start = stat.sort_done;
			end
			ST_SORT_CMP: cmd.sort_cmp = 1'b1;
			ST_DRAIN_RD: cmd.drain_rd = 1'b1;
			ST_DRAIN_OUT: begin
				cmd.drain_next = out_ready;
				cmd.clear = out_ready && stat.drain_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ovf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.clear) ovf_q <= 1'b0;
			else if (in_acc && stat.full) ovf_q <= 1'b1;
		end
	end
endmodule

FILE: design/composite_key_record_sorter_core.sv
// channel    dir  payload
// in         in   key_top..key_lo_lo, tag, last
// out        out  key_top..key_lo_lo, tag, last, ovf
// a record is stored per accepted transfer until full; the last one starts a
// stable insertion sort (read, then compare and write back, per step); drain
// reads, then offers each record; input is held off from sort to end of drain
// asynchronous reset empties the store; output stalls freeze the drain
// depends on cks_pkg, cks_if, cks_ctrl, cks_datapath
module composite_key_record_sorter_core (
	input logic clk,
	input logic arst_n,
	cks_if.sink in_ch,
	cks_if.source out_ch
);
	import cks_pkg::*;

	cmd_t cmd;
	stat_t stat;

	cks_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_last(in_ch.last),
		.out_ready(out_ch.ready), .stat(stat), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_last(out_ch.last), .out_ovf(out_ch.ovf), .cmd(cmd)
	);

	cks_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_rec(in_ch.rec), .stat(stat),
		.rd_rec(out_ch.rec)
	);
endmodule

FILE: tb/cks_sort_checker.sv
// scoreboard for the composite key record sorter: keeps the pending record set,
// sorts it on a last record and queues the expected output records
// depends on cks_pkg
import cks_pkg::*;

typedef struct packed {
	rec_t rec;
	logic last;
	logic ovf;
} sorted_rec_t;

class cks_sort_checker;
	rec_t pending[$];
	bit dropped;
	sorted_rec_t sorted_q[$];
	int errors;
	int sets;
	int matched;

	function new();
		errors = 0;
		sets = 0;
		matched = 0;
		dropped = 0;
	endfunction

	// strict compare on the 144-bit key only, tag excluded
	function bit key_after(rec_t a, rec_t b);
		return a[RecW-1 -: KeyW] > b[RecW-1 -: KeyW];
	endfunction

	function void note_record(rec_t r, logic last);
		rec_t cur;
		int j;
		sorted_rec_t s;
		if (pending.size() < StoreDepth)
			pending.push_back(r);
		else
			dropped = 1;
		if (!last)
			return;
		// stable insertion sort
		for (int i = 1; i < pending.size(); i++) begin
			cur = pending[i];
			j = i;
			while (j > 0 && key_after(pending[j-1], cur)) begin
				pending[j] = pending[j-1];
				j--;
			end
			pending[j] = cur;
		end
		foreach (pending[k]) begin
			s.rec = pending[k];
			s.last = (k == pending.size() - 1);
			s.ovf = dropped;
			sorted_q.push_back(s);
		end
		pending.delete();
		dropped = 0;
		sets++;
	endfunction

	function void check_record(rec_t r, logic last, logic ovf);
		sorted_rec_t e;
		if (sorted_q.size() == 0) begin
			$display("%0t: unexpected output record %h last %b ovf %b", $time, r, last, ovf);
			errors++;
			return;
		end
		e = sorted_q.pop_front();
		if (e.rec !== r || e.last !== last || e.ovf !== ovf) begin
			$display("%0t: mismatch expected rec %h last %b ovf %b", $time, e.rec, e.last, e.ovf);
			$display("%0t:          actual   rec %h last %b ovf %b", $time, r, last, ovf);
			errors++;
		end else
			matched++;
	endfunction
endclass

FILE: tb/composite_key_record_sorter_core_tb.sv
// testbench top for composite_key_record_sorter_core: directed and random record
// sets under varying idle and stall patterns, checked by the scoreboard class
// depends on cks_pkg, cks_if, cks_sort_checker and the design
module composite_key_record_sorter_core_tb;
	import cks_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int unsigned cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 0;
	int hold_len = 0;
	int items_sent = 0;
	cks_sort_checker sb;

	cks_if in_ch ();
	cks_if out_ch ();

	composite_key_record_sorter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #10 clk = ~clk;

	initial begin
		sb = new();
		in_ch.valid = 0;
		in_ch.rec = '0;
		in_ch.last = 0;
		in_ch.ovf = 0;
		out_ch.ready = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// sort is quadratic in the set size, so the timeout leaves ample margin
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("composite_key_record_sorter_core regression: fail");
			$finish;
		end
	end

	// receiver side: random stall or a long counted hold-off
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_record(out_ch.rec, out_ch.last, out_ch.ovf);
		if (hold_off) begin
			out_ch.ready <= 0;
			hold_len <= hold_len + 1;
			if (hold_len >= 400) begin
				hold_off <= 0;
				hold_len <= 0;
			end
		end else
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic rec_t rand_rec();
		rec_t r;
		r.key_top = 16'($urandom);
		r.key_hi_hi = $urandom;
		r.key_hi_lo = $urandom;
		r.key_lo_hi = $urandom;
		r.key_lo_lo = $urandom;
		r.tag = 16'($urandom);
		// narrow key space often so that ties and near ties occur
		case ($urandom_range(3))
			0: begin
				r.key_top = 16'($urandom_range(1));
				r.key_hi_hi = $urandom_range(1);
				r.key_hi_lo = $urandom_range(1);
				r.key_lo_hi = $urandom_range(1);
				r.key_lo_lo = $urandom_range(2);
			end
			1: r.key_top = 16'($urandom_range(3));
			default: ;
		endcase
		return r;
	endfunction

	// valid stays up after acceptance; the next call replaces or drops it, wait_drained drops it
	task automatic send_record(rec_t r, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.rec <= r;
		in_ch.last <= last;
		in_ch.ovf <= 1'($urandom_range(1));
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_record(r, last);
		items_sent++;
	endtask

	task automatic send_set(int n);
		for (int i = 0; i < n; i++)
			send_record(rand_rec(), i == n - 1);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 0;
		while (sb.sorted_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		rec_t r;
		@(posedge arst_n);
		@(posedge clk);
		// directed: extremes of every field, ties, single record set
		r = '0;
		send_record(r, 0);
		r = '1;
		send_record(r, 0);
		r = '0;
		r.tag = 16'h1234;
		send_record(r, 0);
		r = '1;
		r.key_lo_lo = 32'hffff_fffe;
		send_record(r, 0);
		r = '0;
		r.key_top = 16'h8000;
		send_record(r, 0);
		r = '0;
		r.key_lo_lo = 1;
		r.tag = 16'hffff;
		send_record(r, 1);
		r = '1;
		send_record(r, 1);
		// overflow: 66 records, the last two are dropped but the last still triggers output
		send_set(66);
		// two records with identical keys keep arrival order
		r = '0;
		r.tag = 1;
		send_record(r, 0);
		r.tag = 2;
		send_record(r, 1);
		wait_drained();

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 70 : (ph == 3) ? 32 : 0;
			recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 32 : 0;
			repeat (4) send_set(($urandom_range(7) == 0) ? $urandom_range(40, 64)
				: $urandom_range(1, 12));
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 20;
		// long receiver hold-off while further sets queue at the input
		hold_off = 1;
		send_set(5);
		send_set(8);
		wait_drained();
		send_set(65);
		wait_drained();
		while (items_sent < 320)
			send_set($urandom_range(1, 10));
		wait_drained();
		repeat (200) @(posedge clk);
		$display("covered %0d records in %0d sets, %0d sorted records checked",
			items_sent, sb.sets, sb.matched);
		if (sb.errors == 0 && sb.sorted_q.size() == 0)
			$display("composite_key_record_sorter_core regression: pass");
		else
			$display("composite_key_record_sorter_core regression: fail");
		$finish;
	end
endmodule
